### hw/rtl/psw_pkg.sv
// ----------------------------------------------------------------------------
// Priority scheduler shared definitions
// Record and queue entry types and fixed field widths used by the front end,
// the queue and the back end of the non-preemptive priority scheduler.
// ----------------------------------------------------------------------------
package psw_pkg;

   // Fixed field widths of one process record.
   localparam int ID_W    = 16;
   localparam int BURST_W = 16;
   localparam int PRIO_W  = 8;

   // Result field widths.
   localparam int TIME_W = 20;
   localparam int AVG_W  = 28;
   localparam int FRAC_W = 8;

   // Packed stream widths.
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 136;

   // Saturation limits of the result fields.
   localparam logic [TIME_W-1:0] TIME_MAX = '1;
   localparam logic [AVG_W-1:0]  AVG_MAX  = '1;

   // Depth of the queue between the front end and the back end.
   localparam int QUEUE_DEPTH = 4;

   // Default number of records held per set.
   localparam int MAX_PROCS_DEF = 16;

   // One process record as it is stored.
   typedef struct packed {
      logic [ID_W-1:0]    proc_id;
      logic [BURST_W-1:0] burst_time;
      logic [PRIO_W-1:0]  prio_level;
   } rec_type;

   // One classified transaction passed from the front end to the back end.
   typedef struct packed {
      rec_type rec;
      logic    store;   // Record fits in the store and is kept.
      logic    last;    // Record closes the set.
      logic    ovf;     // Some record of this set has been dropped so far.
   } qent_type;

endpackage

### hw/rtl/psw_queue.sv
// ----------------------------------------------------------------------------
// Classified record queue
// Short first-in first-out queue that decouples the loading front end from
// the sorting and output back end.
// ----------------------------------------------------------------------------
module psw_queue
   import psw_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  qent_type push_data,
   output logic     full,
   input  logic     pop,
   output logic     not_empty,
   output qent_type head
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   qent_type             slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     fill_ff, fill_in;
   logic                 do_push, do_pop;

   assign full      = (fill_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (fill_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // Pointer and fill level update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hw/rtl/psw_front.sv
// ----------------------------------------------------------------------------
// Record loader front end
// Accepts process records, tracks how many records of the current set fit
// in the store and marks dropped records, then hands each transaction to
// the queue.
// ----------------------------------------------------------------------------
module psw_front
   import psw_pkg::*;
#(
   parameter int MAX_PROCS = MAX_PROCS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // proc_id, burst_time, prio_level
   input  logic                  req_tlast,  // last_item
   input  logic                  q_full,
   output logic                  q_push,
   output qent_type              q_data
);

   localparam int CNT_W = $clog2(MAX_PROCS + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic             fits;

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;
   assign fits       = (count_ff < CNT_W'(MAX_PROCS));

   // Classify the transaction from the running count of the set.
   always_comb begin
      q_data.rec.proc_id    = req_tdata[15:0];
      q_data.rec.burst_time = req_tdata[31:16];
      q_data.rec.prio_level = req_tdata[39:32];
      q_data.store          = fits;
      q_data.last           = req_tlast;
      q_data.ovf            = ovf_ff || !fits;
   end

   // The count and the drop flag restart after the closing record.
   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (q_push) begin
         if (req_tlast) begin
            count_in = '0;
            ovf_in   = 1'b0;
         end else begin
            count_in = count_ff + CNT_W'(fits);
            ovf_in   = ovf_ff || !fits;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

### hw/rtl/psw_div.sv
// ----------------------------------------------------------------------------
// Radix-2 restoring divider
// Unsigned division that produces one quotient bit per cycle; used for the
// averages of waiting and turnaround time.
// ----------------------------------------------------------------------------
module psw_div
   import psw_pkg::*;
#(
   parameter int NUM_W = 34,
   parameter int DEN_W = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             busy,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int BIT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quot_ff, quot_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [BIT_W-1:0] bits_ff, bits_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   shifted;
   logic [DEN_W:0]   diff;

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = quot_ff;

   assign shifted = {rem_ff, quot_ff[NUM_W-1]};
   assign diff    = shifted - {1'b0, den_ff};

   // One trial subtraction per cycle; the quotient shifts in from the right.
   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      bits_in = bits_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quot_in = num;
         rem_in  = '0;
         den_in  = den;
         bits_in = BIT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DEN_W]) begin
            rem_in  = diff[DEN_W-1:0];
            quot_in = {quot_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted[DEN_W-1:0];
            quot_in = {quot_ff[NUM_W-2:0], 1'b0};
         end
         bits_in = bits_ff - 1'b1;
         if (bits_ff == BIT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         bits_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         bits_ff <= bits_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

endmodule

### hw/rtl/psw_back.sv
// ----------------------------------------------------------------------------
// Scheduler back end
// Stores the records of a set, orders them by ascending priority with an
// exchange sort over a record memory with one write and one read port, sums
// waiting and turnaround times, has the averages divided and emits one
// result per record in schedule order.
// ----------------------------------------------------------------------------
module psw_back
   import psw_pkg::*;
#(
   parameter int MAX_PROCS = MAX_PROCS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  qent_type                      q_head,
   output logic                          q_pop,
   output logic                          div_start,
   output logic [BURST_W+2*$clog2(MAX_PROCS+1)+FRAC_W-1:0] div_num,
   output logic [$clog2(MAX_PROCS+1)-1:0] div_den,
   input  logic                          div_done,
   input  logic [BURST_W+2*$clog2(MAX_PROCS+1)+FRAC_W-1:0] div_quot,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // out_proc_id, out_burst, out_prio, wait_time, turnaround,
   // avg_wait_q8, avg_turn_q8
   output logic [RSP_DATA_W-1:0]         rsp_tdata,
   output logic                          rsp_tuser,  // overflowed
   output logic                          rsp_tlast   // last_result
);

   localparam int CNT_W   = $clog2(MAX_PROCS + 1);
   localparam int IDX_W   = $clog2(MAX_PROCS);
   localparam int RUN_W   = BURST_W + CNT_W;
   localparam int SUM_W   = RUN_W + CNT_W;
   localparam int NUM_W   = SUM_W + FRAC_W;
   localparam int TCMP_W  = (RUN_W > TIME_W) ? RUN_W : TIME_W;
   localparam int ACMP_W  = (NUM_W > AVG_W) ? NUM_W : AVG_W;

   // Sequencer states.
   localparam logic [3:0] ST_LOAD      = 4'd0;
   localparam logic [3:0] ST_SORT_RD   = 4'd1;
   localparam logic [3:0] ST_SORT_LD   = 4'd2;
   localparam logic [3:0] ST_SCAN_RD   = 4'd3;
   localparam logic [3:0] ST_SCAN_CMP  = 4'd4;
   localparam logic [3:0] ST_SORT_WB   = 4'd5;
   localparam logic [3:0] ST_SUM_RD    = 4'd6;
   localparam logic [3:0] ST_SUM_ACC   = 4'd7;
   localparam logic [3:0] ST_DIVW_GO   = 4'd8;
   localparam logic [3:0] ST_DIVW_WAIT = 4'd9;
   localparam logic [3:0] ST_DIVT_GO   = 4'd10;
   localparam logic [3:0] ST_DIVT_WAIT = 4'd11;
   localparam logic [3:0] ST_OUT_RD    = 4'd12;
   localparam logic [3:0] ST_OUT_LD    = 4'd13;
   localparam logic [3:0] ST_OUT_HOLD  = 4'd14;

   logic [3:0]        state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              ovf_ff, ovf_in;
   logic [IDX_W-1:0]  i_ff, i_in;
   logic [IDX_W-1:0]  j_ff, j_in;
   rec_type           cur_ff, cur_in;
   logic [RUN_W-1:0]  run_ff, run_in;
   logic [SUM_W-1:0]  sum_w_ff, sum_w_in;
   logic [SUM_W-1:0]  sum_t_ff, sum_t_in;
   logic [AVG_W-1:0]  avg_w_ff, avg_w_in;
   logic [AVG_W-1:0]  avg_t_ff, avg_t_in;

   // Result register.
   logic              rsp_valid_ff, rsp_valid_in;
   rec_type           out_rec_ff, out_rec_in;
   logic [TIME_W-1:0] out_wait_ff, out_wait_in;
   logic [TIME_W-1:0] out_turn_ff, out_turn_in;
   logic              out_last_ff, out_last_in;

   // Record memory with one write and one registered read port.
   rec_type           mem [MAX_PROCS];
   rec_type           rd_data_ff;
   logic [IDX_W-1:0]  rd_addr;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_wa;
   rec_type           mem_wd;

   logic              i_is_end;
   logic              j_is_end;
   logic [RUN_W-1:0]  run_next;
   logic [TCMP_W-1:0] run_cmp;
   logic [TCMP_W-1:0] turn_cmp;
   logic [ACMP_W-1:0] quot_cmp;
   logic [AVG_W-1:0]  quot_sat;

   assign i_is_end = (CNT_W'(i_ff) + 1'b1 == cnt_ff);
   assign j_is_end = (CNT_W'(j_ff) + 1'b1 == cnt_ff);
   assign run_next = run_ff + RUN_W'(rd_data_ff.burst_time);

   // Saturation of times and averages to their field widths.
   assign run_cmp  = TCMP_W'(run_ff);
   assign turn_cmp = TCMP_W'(run_next);
   assign quot_cmp = ACMP_W'(div_quot);
   assign quot_sat = (quot_cmp > ACMP_W'(AVG_MAX)) ? AVG_MAX : quot_cmp[AVG_W-1:0];

   assign div_num = {sum_w_ff, {FRAC_W{1'b0}}};
   assign div_den = cnt_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Sequencer: load, sort, sum, divide and output.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      cur_in       = cur_ff;
      run_in       = run_ff;
      sum_w_in     = sum_w_ff;
      sum_t_in     = sum_t_ff;
      avg_w_in     = avg_w_ff;
      avg_t_in     = avg_t_ff;
      rsp_valid_in = rsp_valid_ff;
      out_rec_in   = out_rec_ff;
      out_wait_in  = out_wait_ff;
      out_turn_in  = out_turn_ff;
      out_last_in  = out_last_ff;
      rd_addr      = i_ff;
      mem_we       = 1'b0;
      mem_wa       = i_ff;
      mem_wd       = cur_ff;
      q_pop        = 1'b0;
      div_start    = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            q_pop = q_valid;
            if (q_valid) begin
               mem_we = q_head.store;
               mem_wa = cnt_ff[IDX_W-1:0];
               mem_wd = q_head.rec;
               cnt_in = cnt_ff + CNT_W'(q_head.store);
               if (q_head.last) begin
                  ovf_in   = q_head.ovf;
                  i_in     = '0;
                  state_in = ST_SORT_RD;
               end
            end
         end
         ST_SORT_RD: begin
            rd_addr  = i_ff;
            state_in = ST_SORT_LD;
         end
         ST_SORT_LD: begin
            cur_in = rd_data_ff;
            j_in   = i_ff + 1'b1;
            if (i_is_end) begin
               state_in = ST_SORT_WB;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            rd_addr  = j_ff;
            state_in = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            // Exchange when the held record has the larger priority value.
            if (cur_ff.prio_level > rd_data_ff.prio_level) begin
               mem_we = 1'b1;
               mem_wa = j_ff;
               mem_wd = cur_ff;
               cur_in = rd_data_ff;
            end
            j_in = j_ff + 1'b1;
            if (j_is_end) begin
               state_in = ST_SORT_WB;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_SORT_WB: begin
            mem_we = 1'b1;
            mem_wa = i_ff;
            mem_wd = cur_ff;
            if (i_is_end) begin
               i_in     = '0;
               run_in   = '0;
               sum_w_in = '0;
               sum_t_in = '0;
               state_in = ST_SUM_RD;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_SORT_RD;
            end
         end
         ST_SUM_RD: begin
            rd_addr  = i_ff;
            state_in = ST_SUM_ACC;
         end
         ST_SUM_ACC: begin
            sum_w_in = sum_w_ff + SUM_W'(run_ff);
            sum_t_in = sum_t_ff + SUM_W'(run_next);
            run_in   = run_next;
            if (i_is_end) begin
               state_in = ST_DIVW_GO;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_SUM_RD;
            end
         end
         ST_DIVW_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIVW_WAIT;
         end
         ST_DIVW_WAIT: begin
            if (div_done) begin
               avg_w_in = quot_sat;
               // The turnaround sum takes the place of the waiting sum.
               sum_w_in = sum_t_ff;
               state_in = ST_DIVT_GO;
            end
         end
         ST_DIVT_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIVT_WAIT;
         end
         ST_DIVT_WAIT: begin
            if (div_done) begin
               avg_t_in = quot_sat;
               i_in     = '0;
               run_in   = '0;
               state_in = ST_OUT_RD;
            end
         end
         ST_OUT_RD: begin
            rd_addr  = i_ff;
            state_in = ST_OUT_LD;
         end
         ST_OUT_LD: begin
            out_rec_in   = rd_data_ff;
            out_wait_in  = (run_cmp > TCMP_W'(TIME_MAX)) ? TIME_MAX
                                                         : run_cmp[TIME_W-1:0];
            out_turn_in  = (turn_cmp > TCMP_W'(TIME_MAX)) ? TIME_MAX
                                                          : turn_cmp[TIME_W-1:0];
            out_last_in  = i_is_end;
            run_in       = run_next;
            rsp_valid_in = 1'b1;
            state_in     = ST_OUT_HOLD;
         end
         ST_OUT_HOLD: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (out_last_ff) begin
                  cnt_in   = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_LOAD;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      j_ff        <= j_in;
      cur_ff      <= cur_in;
      run_ff      <= run_in;
      sum_w_ff    <= sum_w_in;
      sum_t_ff    <= sum_t_in;
      avg_w_ff    <= avg_w_in;
      avg_t_ff    <= avg_t_in;
      out_rec_ff  <= out_rec_in;
      out_wait_ff <= out_wait_in;
      out_turn_ff <= out_turn_in;
      out_last_ff <= out_last_in;
   end

   // Result transaction fields, first field in the lowest bits.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {avg_t_ff, avg_w_ff, out_turn_ff, out_wait_ff,
                        out_rec_ff.prio_level, out_rec_ff.burst_time,
                        out_rec_ff.proc_id};
   assign rsp_tuser  = ovf_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

### hw/rtl/priority_schedule_wait_times.sv
// ----------------------------------------------------------------------------
// Non-preemptive priority scheduler
// Loads a set of process records, orders it by ascending priority and
// reports waiting time, turnaround and their averages for each process.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Ports                          Content
//   req       in         req_tvalid/tready/tdata/tlast  process record
//   rsp       out        rsp_tvalid/tready/tdata/tuser  scheduled result
//                        rsp_tlast
//
// A record is taken while the queue ahead of the back end has room; the back
// end stores one record per cycle while it is in its load state. After the
// closing record come the exchange sort over the record memory with its one
// write and one read port, the sum pass and the two averages in the
// bit-serial divider. Each result is read, registered and held until the
// result side takes it. Reset is synchronous and clears only control state.
// While a set is sorted or emitted the queue still takes up to four records
// and then holds off the request side; a stalled result holds the back end.
// ----------------------------------------------------------------------------
module priority_schedule_wait_times
   import psw_pkg::*;
#(
   parameter int MAX_PROCS = MAX_PROCS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // proc_id, burst_time, prio_level
   input  logic                  req_tlast,  // last_item
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // out_proc_id, out_burst, out_prio, wait_time, turnaround,
   // avg_wait_q8, avg_turn_q8
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,  // overflowed
   output logic                  rsp_tlast   // last_result
);

   localparam int CNT_W = $clog2(MAX_PROCS + 1);
   localparam int RUN_W = BURST_W + CNT_W;
   localparam int SUM_W = RUN_W + CNT_W;
   localparam int NUM_W = SUM_W + FRAC_W;

   logic             q_push;
   logic             q_full;
   qent_type         q_in;
   logic             q_pop;
   logic             q_valid;
   qent_type         q_head;
   logic             div_start;
   logic             div_busy;
   logic             div_done;
   logic [NUM_W-1:0] div_num;
   logic [CNT_W-1:0] div_den;
   logic [NUM_W-1:0] div_quot;

   // Front end: accepts and classifies records.
   psw_front #(
      .MAX_PROCS(MAX_PROCS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_data     (q_in)
   );

   // Queue between the two halves.
   psw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .head      (q_head)
   );

   // Divider shared by both averages.
   psw_div #(
      .NUM_W(NUM_W),
      .DEN_W(CNT_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Back end: store, sort, sum and emit.
   psw_back #(
      .MAX_PROCS(MAX_PROCS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .div_start  (div_start),
      .div_num    (div_num),
      .div_den    (div_den),
      .div_done   (div_done),
      .div_quot   (div_quot),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTHESIS
   // The front end never offers a transaction to a full queue.
   ap_queue_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("record pushed into a full queue");

   // A division is started only when the divider is free.
   ap_div_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider restarted while busy");

   // The divider is no longer busy when it reports completion.
   ap_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> !div_busy)
      else $error("divider done while still busy");

   // No result is offered right after reset.
   ap_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");
`endif

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority scheduler testbench
// Streams sets of process records into the scheduler and checks every
// scheduled result, field by field, against a predictor. The predictor keeps
// its own record store and repeats the exchange sort, waiting and turnaround
// sums and Q8 averages. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
   import psw_pkg::*;

   localparam int SET_CAPACITY = MAX_PROCS_DEF;
   localparam int ITEM_TARGET  = 320;

   // One scheduled result as it appears on the result channel.
   typedef struct {
      logic [ID_W-1:0]    proc_id;
      logic [BURST_W-1:0] burst;
      logic [PRIO_W-1:0]  prio;
      logic [TIME_W-1:0]  wait_time;
      logic [TIME_W-1:0]  turnaround;
      logic [AVG_W-1:0]   avg_wait;
      logic [AVG_W-1:0]   avg_turn;
      logic               overflowed;
      logic               last;
   } sched_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // proc_id, burst_time, prio_level
   logic                  req_tlast = 1'b0;  // last_item
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // out_proc_id, out_burst, out_prio, wait_time, turnaround,
   // avg_wait_q8, avg_turn_q8
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;  // overflowed
   logic                  rsp_tlast;  // last_result

   // Predictor state: the records of the set being loaded.
   rec_type          held_recs [SET_CAPACITY];
   int               held_count = 0;
   bit               held_dropped = 1'b0;
   sched_result_type pending_results [$];

   // Run statistics.
   int mismatches = 0;
   int records_sent = 0;
   int sets_scheduled = 0;
   int overflow_sets = 0;
   int results_checked = 0;
   bit idle_on = 1'b1;
   int stall_left = 0;

   priority_schedule_wait_times #(
      .MAX_PROCS(SET_CAPACITY)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #6 clock = ~clock;

   // Gap length for either side: mostly none, some short, a few long.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (!idle_on || roll < 60) begin
         return 0;
      end else if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // Sort the held set by priority and queue its expected results.
   function automatic void schedule_set();
      rec_type           ordered [SET_CAPACITY];
      rec_type           swap_rec;
      longint unsigned   elapsed;
      longint unsigned   sum_wait;
      longint unsigned   sum_turn;
      longint unsigned   avg_wait;
      longint unsigned   avg_turn;
      sched_result_type  res;
      for (int i = 0; i < held_count; i++) begin
         ordered[i] = held_recs[i];
      end
      // Exchange sort; ties fall where the swaps leave them.
      for (int i = 0; i < held_count; i++) begin
         for (int j = i; j < held_count; j++) begin
            if (ordered[i].prio_level > ordered[j].prio_level) begin
               swap_rec   = ordered[i];
               ordered[i] = ordered[j];
               ordered[j] = swap_rec;
            end
         end
      end
      elapsed  = 0;
      sum_wait = 0;
      sum_turn = 0;
      for (int i = 0; i < held_count; i++) begin
         sum_wait += elapsed;
         elapsed  += ordered[i].burst_time;
         sum_turn += elapsed;
      end
      avg_wait = (sum_wait << FRAC_W) / longint'(held_count);
      avg_turn = (sum_turn << FRAC_W) / longint'(held_count);
      if (avg_wait > AVG_MAX) avg_wait = AVG_MAX;
      if (avg_turn > AVG_MAX) avg_turn = AVG_MAX;
      elapsed = 0;
      for (int i = 0; i < held_count; i++) begin
         res.proc_id    = ordered[i].proc_id;
         res.burst      = ordered[i].burst_time;
         res.prio       = ordered[i].prio_level;
         res.wait_time  = (elapsed > TIME_MAX) ? TIME_MAX : elapsed[TIME_W-1:0];
         elapsed       += ordered[i].burst_time;
         res.turnaround = (elapsed > TIME_MAX) ? TIME_MAX : elapsed[TIME_W-1:0];
         res.avg_wait   = avg_wait[AVG_W-1:0];
         res.avg_turn   = avg_turn[AVG_W-1:0];
         res.overflowed = held_dropped;
         res.last       = (i == held_count - 1);
         pending_results.push_back(res);
      end
      sets_scheduled++;
      if (held_dropped) overflow_sets++;
      held_count   = 0;
      held_dropped = 1'b0;
   endfunction

   // Drive one record and wait for its transaction, then update the predictor.
   task automatic send_record(input rec_type rec, input bit last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {rec.prio_level, rec.burst_time, rec.proc_id};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      records_sent++;
      if (held_count < SET_CAPACITY) begin
         held_recs[held_count] = rec;
         held_count++;
      end else begin
         held_dropped = 1'b1;
      end
      if (last) schedule_set();
   endtask

   function automatic void check_field(input string name, input longint unsigned want,
                                       input longint unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // Result side: random stalls, and a check of every accepted transaction.
   always @(posedge clock) begin
      sched_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("Unexpected result for process %0d", rsp_tdata[15:0]);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            // Field slices follow the packing order of rsp_tdata.
            check_field("out_proc_id", want.proc_id, rsp_tdata[15:0]);
            check_field("out_burst", want.burst, rsp_tdata[31:16]);
            check_field("out_prio", want.prio, rsp_tdata[39:32]);
            check_field("wait_time", want.wait_time, rsp_tdata[59:40]);
            check_field("turnaround", want.turnaround, rsp_tdata[79:60]);
            check_field("avg_wait_q8", want.avg_wait, rsp_tdata[107:80]);
            check_field("avg_turn_q8", want.avg_turn, rsp_tdata[135:108]);
            check_field("overflowed", want.overflowed, rsp_tuser);
            check_field("last_result", want.last, rsp_tlast);
         end
      end
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         stall_left = pick_gap();
      end
   end

   // Single-record sets with all fields at their lowest and highest values.
   task automatic test_single_records();
      send_record('{proc_id: '0, burst_time: '0, prio_level: '0}, 1'b1);
      send_record('{proc_id: '1, burst_time: '1, prio_level: '1}, 1'b1);
   endtask

   // Equal priorities mixed with a lower one, so the sort reorders the ties.
   task automatic test_tie_order();
      send_record('{proc_id: 16'h0011, burst_time: 16'd7, prio_level: 8'd9}, 1'b0);
      send_record('{proc_id: 16'h0022, burst_time: 16'd3, prio_level: 8'd9}, 1'b0);
      send_record('{proc_id: 16'h0033, burst_time: 16'd5, prio_level: 8'd3}, 1'b0);
      send_record('{proc_id: 16'h0044, burst_time: 16'd1, prio_level: 8'd9}, 1'b1);
   endtask

   // A full store of longest bursts, then a closing record that is dropped.
   task automatic test_store_overflow();
      rec_type rec;
      for (int i = 0; i <= SET_CAPACITY; i++) begin
         rec.proc_id    = 16'hA000 + 16'(i);
         rec.burst_time = '1;
         rec.prio_level = 8'(255 - 13 * i);
         send_record(rec, i == SET_CAPACITY);
      end
   endtask

   // Random sets: mostly small, some larger up to a full store, a few that overflow it.
   task automatic test_random_sets();
      rec_type rec;
      int      set_size;
      int      roll;
      bit      narrow_prio;
      bit      short_burst;
      while (records_sent < ITEM_TARGET) begin
         roll = $urandom_range(0, 99);
         if (roll < 70) begin
            set_size = $urandom_range(1, 6);
         end else if (roll < 90) begin
            set_size = $urandom_range(7, SET_CAPACITY);
         end else begin
            set_size = $urandom_range(SET_CAPACITY + 1, SET_CAPACITY + 4);
         end
         narrow_prio = 1'($urandom_range(0, 1));
         short_burst = 1'($urandom_range(0, 1));
         idle_on     = ($urandom_range(0, 3) != 0);
         for (int i = 0; i < set_size; i++) begin
            rec.proc_id    = 16'($urandom_range(0, 65535));
            rec.burst_time = short_burst ? 16'($urandom_range(0, 15))
                                         : 16'($urandom_range(0, 65535));
            rec.prio_level = narrow_prio ? 8'($urandom_range(0, 3))
                                         : 8'($urandom_range(0, 255));
            send_record(rec, i == set_size - 1);
         end
      end
      idle_on = 1'b1;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_single_records();
      test_tie_order();
      test_store_overflow();
      test_random_sets();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
      $display("Ran %0d records in %0d sets, %0d of them with dropped records.",
               records_sent, sets_scheduled, overflow_sets);
      $display("Checked %0d scheduled results.", results_checked);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("Timeout with %0d results outstanding.", pending_results.size());
      $display("Some tests failed");
      $finish;
   end

endmodule
